[rtl/core/length_prefixed_frame_receiver_unit_assert.svh]
// Assertion macros for the length-prefixed frame receiver.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LPFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LPFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `LPFR_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)
`else
`define LPFR_ASSERT(lbl, clk, rstn, prop, msg)
`define LPFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/core/lpfr_pkg.sv]
// Shared types and constants for the length-prefixed frame receiver.
// No dependencies.
package lpfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_START_CODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_END_CODE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ACK_CODE   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_NACK_CODE  = 2'd3;

  localparam logic [ByteW-1:0] START_CODE_RST = 8'h0F;
  localparam logic [ByteW-1:0] END_CODE_RST   = 8'hF0;
  localparam logic [ByteW-1:0] ACK_CODE_RST   = 8'h79;
  localparam logic [ByteW-1:0] NACK_CODE_RST  = 8'h7F;

  // length, address high, address low and checksum around the payload
  localparam logic [IdxW:0] FRAME_OVERHEAD = 10'd4;
  localparam logic [IdxW-1:0] IDX_MAX = 9'd258;

  typedef struct packed {
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] end_code;
    logic [ByteW-1:0] ack_code;
    logic [ByteW-1:0] nack_code;
  } cfg_t;

  typedef struct packed {
    logic             reply_valid;
    logic [ByteW-1:0] reply_byte;
    logic             frame_done;
    logic             checksum_ok;
    logic             session_active;
    logic [ByteW-1:0] frames_accepted;
  } result_t;

endpackage

[rtl/core/lpfr_cfg_regs.sv]
// Code registers of the frame receiver, written through a plain write port.
// Depends on lpfr_pkg.
module lpfr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lpfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lpfr_pkg::ByteW-1:0]   cfg_wdata_i,
  output lpfr_pkg::cfg_t               cfg_o
);

  lpfr_pkg::cfg_t cfg_q;
  lpfr_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpfr_pkg::REG_START_CODE: cfg_d.start_code = cfg_wdata_i;
        lpfr_pkg::REG_END_CODE:   cfg_d.end_code   = cfg_wdata_i;
        lpfr_pkg::REG_ACK_CODE:   cfg_d.ack_code   = cfg_wdata_i;
        lpfr_pkg::REG_NACK_CODE:  cfg_d.nack_code  = cfg_wdata_i;
        default:                  cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code <= lpfr_pkg::START_CODE_RST;
      cfg_q.end_code   <= lpfr_pkg::END_CODE_RST;
      cfg_q.ack_code   <= lpfr_pkg::ACK_CODE_RST;
      cfg_q.nack_code  <= lpfr_pkg::NACK_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/lpfr_frame_core.sv]
// Frame state and per-word decode: session, byte position, running XOR, count.
// Depends on lpfr_pkg and the assertion macro header.
`include "length_prefixed_frame_receiver_unit_assert.svh"
module lpfr_frame_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [lpfr_pkg::ByteW-1:0] rx_byte_i,
  input  lpfr_pkg::cfg_t             cfg_i,
  output lpfr_pkg::result_t          result_o
);

  logic                       boundary_q, boundary_d;
  logic                       session_q, session_d;
  logic [lpfr_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [lpfr_pkg::ByteW-1:0] len_q, len_d;
  logic [lpfr_pkg::ByteW-1:0] csum_q, csum_d;
  logic [lpfr_pkg::ByteW-1:0] count_q, count_d;
  logic [lpfr_pkg::ByteW-1:0] len_eff;
  logic [lpfr_pkg::IdxW:0]    total;
  logic [lpfr_pkg::IdxW:0]    idx_inc;
  logic                       last_byte;
  logic                       sum_match;

  assign len_eff   = (idx_q == '0) ? rx_byte_i : len_q;
  assign total     = {2'b00, len_eff} + lpfr_pkg::FRAME_OVERHEAD;
  assign idx_inc   = {1'b0, idx_q} + 10'd1;
  assign last_byte = (idx_inc >= total);
  assign sum_match = (rx_byte_i == csum_q);

  always_comb begin
    boundary_d = boundary_q;
    session_d  = session_q;
    idx_d      = idx_q;
    len_d      = len_q;
    csum_d     = csum_q;
    count_d    = count_q;
    result_o   = '0;
    priority if (boundary_q && (rx_byte_i == cfg_i.start_code)) begin
      session_d             = 1'b1;
      boundary_d            = 1'b0;
      idx_d                 = '0;
      csum_d                = '0;
      result_o.reply_valid  = 1'b1;
      result_o.reply_byte   = cfg_i.ack_code;
    end else if (boundary_q && (rx_byte_i == cfg_i.end_code)) begin
      session_d             = 1'b0;
      boundary_d            = 1'b1;
      idx_d                 = '0;
      csum_d                = '0;
      result_o.reply_valid  = 1'b1;
      result_o.reply_byte   = cfg_i.ack_code;
    end else begin
      boundary_d = 1'b0;
      len_d      = len_eff;
      if (last_byte) begin
        result_o.frame_done  = 1'b1;
        result_o.checksum_ok = sum_match;
        idx_d                = '0;
        csum_d               = '0;
        boundary_d           = 1'b1;
        if (session_q) begin
          result_o.reply_valid = 1'b1;
          if (sum_match) begin
            count_d             = count_q + 8'd1;
            result_o.reply_byte = cfg_i.ack_code;
          end else begin
            result_o.reply_byte = cfg_i.nack_code;
          end
        end
      end else begin
        csum_d = csum_q ^ rx_byte_i;
        idx_d  = idx_inc[lpfr_pkg::IdxW-1:0];
      end
    end
    if (!session_d) begin
      count_d = '0;
    end
    result_o.session_active  = session_d;
    result_o.frames_accepted = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boundary_q <= 1'b1;
      session_q  <= 1'b0;
      idx_q      <= '0;
      len_q      <= '0;
      csum_q     <= '0;
      count_q    <= '0;
    end else if (advance_i) begin
      boundary_q <= boundary_d;
      session_q  <= session_d;
      idx_q      <= idx_d;
      len_q      <= len_d;
      csum_q     <= csum_d;
      count_q    <= count_d;
    end
  end

  `LPFR_ASSERT(a_boundary_idx, clk_i, rst_ni, boundary_q |-> (idx_q == '0), "index not zero at boundary")
  `LPFR_ASSERT(a_idx_range, clk_i, rst_ni, idx_q <= lpfr_pkg::IDX_MAX, "byte index past longest frame")
  `LPFR_ASSERT(a_count_session, clk_i, rst_ni, !session_q |-> (count_q == '0), "count held outside session")
  `LPFR_ASSERT_NEXT(a_done_boundary, clk_i, rst_ni, advance_i && result_o.frame_done, boundary_q, "no boundary after frame")

endmodule

[rtl/core/length_prefixed_frame_receiver_unit.sv]
// Length-prefixed frame receiver with XOR checksum: one result word per rx word.
// Words pass input register then result register; 1 word/cycle unless stalled.
// Input register, frame state and result register each hold one word; the
// output stalls back through the input register only.
// Reset (async, active low) restores default codes, boundary state, no session.
// Depends on lpfr_pkg, lpfr_cfg_regs, lpfr_frame_core and the assertion header.
`include "length_prefixed_frame_receiver_unit_assert.svh"
module length_prefixed_frame_receiver_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lpfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lpfr_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lpfr_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         reply_valid_o,
  output logic [lpfr_pkg::ByteW-1:0]   reply_byte_o,
  output logic                         frame_done_o,
  output logic                         checksum_ok_o,
  output logic                         session_active_o,
  output logic [lpfr_pkg::ByteW-1:0]   frames_accepted_o
);

  lpfr_pkg::cfg_t             cfg;
  lpfr_pkg::result_t          result;
  lpfr_pkg::result_t          res_q;
  logic [lpfr_pkg::ByteW-1:0] byte_q;
  logic                       in_valid_q, in_valid_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free;
  logic                       advance;
  logic                       in_take;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  lpfr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lpfr_frame_core u_frame_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .rx_byte_i (byte_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign reply_valid_o     = res_q.reply_valid;
  assign reply_byte_o      = res_q.reply_byte;
  assign frame_done_o      = res_q.frame_done;
  assign checksum_ok_o     = res_q.checksum_ok;
  assign session_active_o  = res_q.session_active;
  assign frames_accepted_o = res_q.frames_accepted;

  `LPFR_ASSERT_NEXT(a_advance_fills, clk_i, rst_ni, advance, out_valid_q,
                    "result register not loaded")
  `LPFR_ASSERT(a_ok_done, clk_i, rst_ni,
               (out_valid_q && res_q.checksum_ok) |-> res_q.frame_done,
               "checksum flag without frame")
  `LPFR_ASSERT(a_quiet_outside, clk_i, rst_ni,
               (out_valid_q && res_q.frame_done && !res_q.session_active) |-> !res_q.reply_valid,
               "reply to frame outside session")

endmodule

[verif/testbench.sv]
// Testbench for length_prefixed_frame_receiver_unit: drives rx words through the
// valid/ready ports, predicts each reply word and checks it field by field.
// Depends on lpfr_pkg and the RTL of the block.
`timescale 1ns / 100ps
module testbench;
  import lpfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  class reply_scoreboard;
    cfg_t              codes;
    bit                awaiting_frame_start;
    bit                in_session;
    logic [IdxW-1:0]   word_pos;
    logic [ByteW-1:0]  cur_len;
    logic [ByteW-1:0]  xor_sum;
    logic [ByteW-1:0]  accepted_count;
    result_t           pending_replies[$];
    int                mismatches;
    int                replies_checked;
    int                good_frames;
    int                bad_frames;

    function new();
      codes = '{START_CODE_RST, END_CODE_RST, ACK_CODE_RST, NACK_CODE_RST};
      awaiting_frame_start = 1'b1;
      in_session = 1'b0;
      word_pos = '0;
      cur_len = '0;
      xor_sum = '0;
      accepted_count = '0;
    endfunction

    function void set_code(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        REG_START_CODE: codes.start_code = val;
        REG_END_CODE:   codes.end_code = val;
        REG_ACK_CODE:   codes.ack_code = val;
        REG_NACK_CODE:  codes.nack_code = val;
        default: ;
      endcase
    endfunction

    function void note_rx_word(logic [ByteW-1:0] w);
      result_t r;
      int      total;
      r = '0;
      if (awaiting_frame_start && w == codes.start_code) begin
        in_session = 1'b1;
        awaiting_frame_start = 1'b0;
        word_pos = '0;
        xor_sum = '0;
        r.reply_valid = 1'b1;
        r.reply_byte = codes.ack_code;
      end else if (awaiting_frame_start && w == codes.end_code) begin
        in_session = 1'b0;
        word_pos = '0;
        xor_sum = '0;
        r.reply_valid = 1'b1;
        r.reply_byte = codes.ack_code;
      end else begin
        awaiting_frame_start = 1'b0;
        if (word_pos == 0) cur_len = w;
        total = 4 + int'(cur_len);
        if (int'(word_pos) + 1 >= total) begin
          r.frame_done = 1'b1;
          r.checksum_ok = (w == xor_sum);
          word_pos = '0;
          xor_sum = '0;
          awaiting_frame_start = 1'b1;
          if (r.checksum_ok) good_frames++;
          else bad_frames++;
          if (in_session) begin
            r.reply_valid = 1'b1;
            if (r.checksum_ok) begin
              accepted_count = accepted_count + 8'd1;
              r.reply_byte = codes.ack_code;
            end else begin
              r.reply_byte = codes.nack_code;
            end
          end
        end else begin
          xor_sum = xor_sum ^ w;
          word_pos = word_pos + 1'b1;
        end
      end
      if (!in_session) accepted_count = '0;
      r.session_active = in_session;
      r.frames_accepted = accepted_count;
      pending_replies.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply word, expected none actual 0x%0h", $time, got);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      compare_field("reply_valid", want.reply_valid, got.reply_valid);
      compare_field("reply_byte", want.reply_byte, got.reply_byte);
      compare_field("frame_done", want.frame_done, got.frame_done);
      compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
      compare_field("session_active", want.session_active, got.session_active);
      compare_field("frames_accepted", want.frames_accepted, got.frames_accepted);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [ByteW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ByteW-1:0]    rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                reply_valid_o;
  logic [ByteW-1:0]    reply_byte_o;
  logic                frame_done_o;
  logic                checksum_ok_o;
  logic                session_active_o;
  logic [ByteW-1:0]    frames_accepted_o;

  reply_scoreboard sb;
  result_t         seen_reply;
  int              words_sent;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              hold_off_left;
  int              cycle_count;

  length_prefixed_frame_receiver_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i = 1'b0;
      hold_off_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_reply.reply_valid = reply_valid_o;
      seen_reply.reply_byte = reply_byte_o;
      seen_reply.frame_done = frame_done_o;
      seen_reply.checksum_ok = checksum_ok_o;
      seen_reply.session_active = session_active_o;
      seen_reply.frames_accepted = frames_accepted_o;
      sb.check_reply(seen_reply);
    end
  end

  task automatic send_word(input logic [ByteW-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    rx_byte_i = w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_rx_word(w);
    words_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input bit corrupt);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] w;
    int unsigned      k;
    sum = 8'(len);
    send_word(8'(len));
    for (k = 0; k < len + 2; k++) begin
      w = 8'($urandom_range(255));
      sum = sum ^ w;
      send_word(w);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(255, 1));
    send_word(sum);
  endtask

  task automatic wait_for_replies();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_code(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    sb.set_code(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic program_codes(input logic [ByteW-1:0] start_c, input logic [ByteW-1:0] end_c,
                               input logic [ByteW-1:0] ack_c, input logic [ByteW-1:0] nack_c);
    wait_for_replies();
    write_code(REG_START_CODE, start_c);
    write_code(REG_END_CODE, end_c);
    write_code(REG_ACK_CODE, ack_c);
    write_code(REG_NACK_CODE, nack_c);
  endtask

  task automatic run_random_traffic(input int count);
    int stop_at;
    int pick;
    int n;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_word(sb.codes.start_code);
      end else if (pick < 14) begin
        send_word(sb.codes.end_code);
      end else if (pick < 22) begin
        n = $urandom_range(5, 1);
        repeat (n) send_word(8'($urandom_range(255)));
      end else begin
        send_frame(($urandom_range(29) == 0) ? $urandom_range(40, 9) : $urandom_range(6),
                   $urandom_range(4) == 0);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_START_CODE;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    out_ready_i = 1'b0;
    words_sent = 0;
    hold_off_left = 0;
    cycle_count = 0;
    send_idle_pct = 7;
    recv_idle_pct = 70;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // default codes: end outside a session, frame outside, session with codes as data
    send_word(END_CODE_RST);
    send_word(8'h00);
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'hFF);
    send_word(START_CODE_RST);
    send_word(8'h02);
    send_word(8'h12);
    send_word(8'h34);
    send_word(START_CODE_RST);
    send_word(END_CODE_RST);
    send_word(8'h02 ^ 8'h12 ^ 8'h34 ^ START_CODE_RST ^ END_CODE_RST);
    send_word(START_CODE_RST);
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'h00);
    send_word(8'h00);
    send_word(END_CODE_RST);
    send_word(END_CODE_RST);
    run_random_traffic(100);

    // extreme codes; a code-valued length right after the start code
    program_codes(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_word(8'h00);
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'hFF);
    send_word(8'h00);
    send_word(8'hFF);
    hold_off_left = 60;
    run_random_traffic(100);

    program_codes(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_idle_pct = 70;
    recv_idle_pct = 7;
    run_random_traffic(100);

    program_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(sb.codes.start_code);
    send_frame(255, 1'b0);
    send_word(sb.codes.end_code);
    run_random_traffic(60);

    wait_for_replies();
    $display("Covered %0d rx words under four code settings: %0d good and %0d bad frames,",
             words_sent, sb.good_frames, sb.bad_frames);
    $display("a 255-byte frame, stalls on both sides and %0d checked replies.",
             sb.replies_checked);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lpfr_pkg.sv
rtl/core/lpfr_cfg_regs.sv
rtl/core/lpfr_frame_core.sv
rtl/core/length_prefixed_frame_receiver_unit.sv
verif/testbench.sv
